>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset disable.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/nrag_pkg.sv
// Shared widths, register indexes and divider status types for the resize address generator.
// No dependencies.
`default_nettype none

package nrag_pkg;

  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 3;
  localparam int STRIDE_W   = 15;
  localparam int OFS_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int STRIDE_MAX = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_CHANNEL_COUNT,
    REG_SRC_ROW_STRIDE,
    REG_DST_ROW_STRIDE
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] whole;
    logic [DIM_W-1:0] rem;
  } quot_t;

  typedef struct packed {
    logic  busy;
    quot_t quot;
  } div_status_t;

endpackage

`default_nettype wire

>>> sv/nrag_div.sv
// Shift-subtract divider: one quotient bit per cycle, DIM_W quotient bits per division.
// Depends on nrag_pkg.
`default_nettype none

module nrag_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nrag_pkg::DIM_W-1:0]   dividend,
  input  logic [nrag_pkg::DIM_W-1:0]   divisor,
  output nrag_pkg::div_status_t        status
);

  localparam int W     = nrag_pkg::DIM_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] count;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  assign trial = {rem, quo[W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // reset result is 1 / 1
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      quo   <= W'(1);
      rem   <= '0;
    end else if (start) begin
      count <= CNT_W'(W);
      quo   <= dividend;
      rem   <= '0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      rem   <= fits ? diff[W-1:0] : trial[W-1:0];
      quo   <= {quo[W-2:0], fits};
    end
  end

  assign status.busy       = count != '0;
  assign status.quot.whole = quo;
  assign status.quot.rem   = rem;

endmodule

`default_nettype wire

>>> sv/nearest_resize_address_gen.sv
// Nearest-neighbor resize address generator: one output pixel per request in raster order,
// with the nearest source pixel and both element offsets. Depends on nrag_pkg, nrag_div.
//
// One request is taken per clock while the result side keeps up and no divider is busy;
// each result passes the coordinates stage, then the offset multiply stage. A write to any of
// the four dimension registers starts the two shift-subtract dividers that form the source
// step quotients; request input is held off after such a write until the load is done and
// both dividers have formed all 13 quotient bits. Other register writes take effect at once.
`default_nettype none

module nearest_resize_address_gen #(
  parameter int MAX_DIM      = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [nrag_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nrag_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 restart_frame,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nrag_pkg::COORD_W-1:0]         dst_row,
  output logic [nrag_pkg::COORD_W-1:0]         dst_col,
  output logic [nrag_pkg::COORD_W-1:0]         src_row,
  output logic [nrag_pkg::COORD_W-1:0]         src_col,
  output logic [nrag_pkg::OFS_W-1:0]           src_offset,
  output logic [nrag_pkg::OFS_W-1:0]           dst_offset,
  output logic                                 row_end,
  output logic                                 frame_end
);

  localparam int DW = nrag_pkg::DIM_W;
  localparam int CW = nrag_pkg::COORD_W;
  localparam int HW = nrag_pkg::CHAN_W;
  localparam int SW = nrag_pkg::STRIDE_W;
  localparam int OW = nrag_pkg::OFS_W;

  typedef struct packed {
    logic [CW-1:0] idx;
    logic [DW-1:0] acc;
  } pos_t;

  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) r = DW'(1);
    else if (int'(v) > MAX_DIM) r = DW'(MAX_DIM);
    return r;
  endfunction

  function automatic pos_t advance(input logic [CW-1:0] idx, input logic [DW-1:0] acc,
                                   input logic [DW-1:0] whole, input logic [DW-1:0] rem,
                                   input logic [DW-1:0] out_size,
                                   input logic [DW-1:0] in_size);
    logic [DW:0] i;
    logic [DW:0] a;
    pos_t        p;
    i = {{(DW+1-CW){1'b0}}, idx} + {1'b0, whole};
    a = {1'b0, acc} + {1'b0, rem};
    if (a >= {1'b0, out_size}) begin
      a = a - {1'b0, out_size};
      i = i + 1'b1;
    end
    if (i > {1'b0, in_size} - 1'b1) i = {1'b0, in_size} - 1'b1;
    p.idx = i[CW-1:0];
    p.acc = a[DW-1:0];
    return p;
  endfunction

  // configuration
  logic [DW-1:0] src_width, src_height, dst_width, dst_height;
  logic [HW-1:0] channel_count;
  logic [SW-1:0] src_row_stride, dst_row_stride;
  logic          dim_dirty;
  logic          dim_write;

  assign dim_write = cfg_write && (cfg_index == nrag_pkg::REG_SRC_WIDTH ||
                                   cfg_index == nrag_pkg::REG_SRC_HEIGHT ||
                                   cfg_index == nrag_pkg::REG_DST_WIDTH ||
                                   cfg_index == nrag_pkg::REG_DST_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width      <= DW'(1);
      src_height     <= DW'(1);
      dst_width      <= DW'(1);
      dst_height     <= DW'(1);
      channel_count  <= HW'(1);
      src_row_stride <= SW'(1);
      dst_row_stride <= SW'(1);
      dim_dirty      <= 1'b0;
    end else begin
      dim_dirty <= dim_write;
      if (cfg_write) begin
        case (cfg_index)
          nrag_pkg::REG_SRC_WIDTH:      src_width      <= cfg_data[DW-1:0];
          nrag_pkg::REG_SRC_HEIGHT:     src_height     <= cfg_data[DW-1:0];
          nrag_pkg::REG_DST_WIDTH:      dst_width      <= cfg_data[DW-1:0];
          nrag_pkg::REG_DST_HEIGHT:     dst_height     <= cfg_data[DW-1:0];
          nrag_pkg::REG_CHANNEL_COUNT:  channel_count  <= cfg_data[HW-1:0];
          nrag_pkg::REG_SRC_ROW_STRIDE: src_row_stride <= cfg_data[SW-1:0];
          nrag_pkg::REG_DST_ROW_STRIDE: dst_row_stride <= cfg_data[SW-1:0];
          default: ;
        endcase
      end
    end
  end

  // effective sizes
  logic [DW-1:0] sw_eff, sh_eff, dw_eff, dh_eff;
  logic [HW-1:0] ch_eff;
  logic [SW-1:0] ss_eff, ds_eff;

  assign sw_eff = eff_dim(src_width);
  assign sh_eff = eff_dim(src_height);
  assign dw_eff = eff_dim(dst_width);
  assign dh_eff = eff_dim(dst_height);

  always_comb begin
    ch_eff = channel_count;
    if (channel_count == '0) ch_eff = HW'(1);
    else if (int'(channel_count) > MAX_CHANNELS) ch_eff = HW'(MAX_CHANNELS);
    ss_eff = src_row_stride;
    if (src_row_stride == '0) ss_eff = SW'(1);
    else if (int'(src_row_stride) > nrag_pkg::STRIDE_MAX) ss_eff = SW'(nrag_pkg::STRIDE_MAX);
    ds_eff = dst_row_stride;
    if (dst_row_stride == '0) ds_eff = SW'(1);
    else if (int'(dst_row_stride) > nrag_pkg::STRIDE_MAX) ds_eff = SW'(nrag_pkg::STRIDE_MAX);
  end

  // step quotients
  nrag_pkg::div_status_t row_div;
  nrag_pkg::div_status_t col_div;

  nrag_div u_row_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dim_dirty),
    .dividend (sh_eff),
    .divisor  (dh_eff),
    .status   (row_div)
  );

  nrag_div u_col_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dim_dirty),
    .dividend (sw_eff),
    .divisor  (dw_eff),
    .status   (col_div)
  );

  // walk state
  logic [CW-1:0] cur_out_row, cur_out_col, cur_src_row, cur_src_col;
  logic [DW-1:0] row_fraction_acc, col_fraction_acc;
  logic [DW-1:0] row_step_whole, row_step_rem, col_step_whole, col_step_rem;

  logic          pipe_move;
  logic          accept;
  logic          fs;
  logic [CW-1:0] row_c, col_c, srow_c, scol_c;
  logic [DW-1:0] racc_c, cacc_c;
  logic [DW-1:0] rwhole_c, rrem_c, cwhole_c, crem_c;
  logic [CW-1:0] sr, sc;
  logic          last_col, last_row;
  pos_t          rpos, cpos;

  logic [CW-1:0] cur_out_row_next, cur_out_col_next, cur_src_row_next, cur_src_col_next;
  logic [DW-1:0] row_fraction_acc_next, col_fraction_acc_next;

  assign pipe_move = !out_valid || out_ready;
  assign in_ready  = pipe_move && !dim_dirty && !row_div.busy && !col_div.busy;
  assign accept    = in_valid && in_ready;

  always_comb begin
    fs       = restart_frame || (cur_out_row == '0 && cur_out_col == '0);
    row_c    = fs ? '0 : cur_out_row;
    col_c    = fs ? '0 : cur_out_col;
    srow_c   = fs ? '0 : cur_src_row;
    scol_c   = fs ? '0 : cur_src_col;
    racc_c   = fs ? '0 : row_fraction_acc;
    cacc_c   = fs ? '0 : col_fraction_acc;
    rwhole_c = fs ? row_div.quot.whole : row_step_whole;
    rrem_c   = fs ? row_div.quot.rem   : row_step_rem;
    cwhole_c = fs ? col_div.quot.whole : col_step_whole;
    crem_c   = fs ? col_div.quot.rem   : col_step_rem;

    sr = ({1'b0, srow_c} > sh_eff - 1'b1) ? CW'(sh_eff - 1'b1) : srow_c;
    sc = ({1'b0, scol_c} > sw_eff - 1'b1) ? CW'(sw_eff - 1'b1) : scol_c;
    last_col = ({1'b0, col_c} + 1'b1) >= dw_eff;
    last_row = ({1'b0, row_c} + 1'b1) >= dh_eff;

    rpos = advance(srow_c, racc_c, rwhole_c, rrem_c, dh_eff, sh_eff);
    cpos = advance(scol_c, cacc_c, cwhole_c, crem_c, dw_eff, sw_eff);

    cur_out_row_next      = row_c;
    cur_out_col_next      = col_c + 1'b1;
    cur_src_row_next      = srow_c;
    cur_src_col_next      = cpos.idx;
    row_fraction_acc_next = racc_c;
    col_fraction_acc_next = cpos.acc;
    if (last_col) begin
      cur_out_col_next      = '0;
      cur_src_col_next      = '0;
      col_fraction_acc_next = '0;
      if (last_row) begin
        cur_out_row_next      = '0;
        cur_src_row_next      = '0;
        row_fraction_acc_next = '0;
      end else begin
        cur_out_row_next      = row_c + 1'b1;
        cur_src_row_next      = rpos.idx;
        row_fraction_acc_next = rpos.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_out_row      <= '0;
      cur_out_col      <= '0;
      cur_src_row      <= '0;
      cur_src_col      <= '0;
      row_fraction_acc <= '0;
      col_fraction_acc <= '0;
      row_step_whole   <= '0;
      row_step_rem     <= '0;
      col_step_whole   <= '0;
      col_step_rem     <= '0;
    end else if (accept) begin
      cur_out_row      <= cur_out_row_next;
      cur_out_col      <= cur_out_col_next;
      cur_src_row      <= cur_src_row_next;
      cur_src_col      <= cur_src_col_next;
      row_fraction_acc <= row_fraction_acc_next;
      col_fraction_acc <= col_fraction_acc_next;
      row_step_whole   <= rwhole_c;
      row_step_rem     <= rrem_c;
      col_step_whole   <= cwhole_c;
      col_step_rem     <= crem_c;
    end
  end

  // stage 1: coordinates
  logic          s1_valid;
  logic [CW-1:0] s1_dst_row, s1_dst_col, s1_src_row, s1_src_col;
  logic          s1_row_end, s1_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_move) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_dst_row   <= row_c;
      s1_dst_col   <= col_c;
      s1_src_row   <= sr;
      s1_src_col   <= sc;
      s1_row_end   <= last_col;
      s1_frame_end <= last_col && last_row;
    end
  end

  // stage 2: offsets
  logic [CW+SW-1:0] src_prod, dst_prod;
  logic [CW+HW-1:0] src_cprod, dst_cprod;
  logic [CW+SW-1:0] src_sum, dst_sum;

  assign src_prod  = s1_src_row * ss_eff;
  assign dst_prod  = s1_dst_row * ds_eff;
  assign src_cprod = s1_src_col * ch_eff;
  assign dst_cprod = s1_dst_col * ch_eff;
  assign src_sum   = src_prod + (CW+SW)'(src_cprod);
  assign dst_sum   = dst_prod + (CW+SW)'(dst_cprod);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pipe_move) begin
      out_valid <= s1_valid;
    end
    if (pipe_move && s1_valid) begin
      dst_row    <= s1_dst_row;
      dst_col    <= s1_dst_col;
      src_row    <= s1_src_row;
      src_col    <= s1_src_col;
      src_offset <= src_sum[OW-1:0];
      dst_offset <= dst_sum[OW-1:0];
      row_end    <= s1_row_end;
      frame_end  <= s1_frame_end;
    end
  end

endmodule

`default_nettype wire

>>> sv/nrag_checker.sv
// Port-level checks for nearest_resize_address_gen, bound to the top level.
// Depends on nrag_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nrag_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [nrag_pkg::COORD_W-1:0]   dst_row,
  input logic [nrag_pkg::COORD_W-1:0]   dst_col,
  input logic [nrag_pkg::COORD_W-1:0]   src_col,
  input logic [nrag_pkg::OFS_W-1:0]     src_offset,
  input logic [nrag_pkg::OFS_W-1:0]     dst_offset,
  input logic                           row_end,
  input logic                           frame_end
);

  `ASSERT_AT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(src_offset) && $stable(dst_offset), "stalled result changed")
  `ASSERT_IMPL(a_frame_row_end, clk, rst, out_valid && frame_end, row_end, "frame end without row end")
  `ASSERT_IMPL(a_origin_zero, clk, rst, out_valid && dst_row == '0 && dst_col == '0, src_offset == '0 && dst_offset == '0, "origin pixel with nonzero offset")
  `ASSERT_IMPL(a_col0_src0, clk, rst, out_valid && dst_col == '0, src_col == '0, "first column maps past source column zero")

endmodule

bind nearest_resize_address_gen nrag_checker u_nrag_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .dst_row    (dst_row),
  .dst_col    (dst_col),
  .src_col    (src_col),
  .src_offset (src_offset),
  .dst_offset (dst_offset),
  .row_end    (row_end),
  .frame_end  (frame_end)
);

`default_nettype wire

>>> tb/tb_nearest_resize_address_gen.sv
// Testbench for nearest_resize_address_gen: a directed table, then random register
// phases, each request checked against a literal expectation or a cycle-free pixel address predictor.
// Depends on nrag_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_nearest_resize_address_gen;

  localparam int DIM_W      = nrag_pkg::DIM_W;
  localparam int COORD_W    = nrag_pkg::COORD_W;
  localparam int CHAN_W     = nrag_pkg::CHAN_W;
  localparam int STRIDE_W   = nrag_pkg::STRIDE_W;
  localparam int OFS_W      = nrag_pkg::OFS_W;
  localparam int CFG_IDX_W  = nrag_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = nrag_pkg::CFG_DATA_W;
  localparam int STRIDE_MAX = nrag_pkg::STRIDE_MAX;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int DIM_LIMIT = 4096;
  localparam int CHAN_LIMIT = 4;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic [OFS_W-1:0]   src_offset;
    logic [OFS_W-1:0]   dst_offset;
    logic               row_end;
    logic               frame_end;
  } pixel_addr_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    logic                  has_lit;
    pixel_addr_t           lit;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  restart_frame;
  logic                  out_valid;
  logic                  out_ready;
  logic [COORD_W-1:0]    dst_row;
  logic [COORD_W-1:0]    dst_col;
  logic [COORD_W-1:0]    src_row;
  logic [COORD_W-1:0]    src_col;
  logic [OFS_W-1:0]      src_offset;
  logic [OFS_W-1:0]      dst_offset;
  logic                  row_end;
  logic                  frame_end;

  nearest_resize_address_gen u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart_frame(restart_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dst_row      (dst_row),
    .dst_col      (dst_col),
    .src_row      (src_row),
    .src_col      (src_col),
    .src_offset   (src_offset),
    .dst_offset   (dst_offset),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

  // predictor copy of the registers
  logic [DIM_W-1:0]    reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
  logic [CHAN_W-1:0]   reg_chan;
  logic [STRIDE_W-1:0] reg_src_stride, reg_dst_stride;

  // predictor walk state
  logic [COORD_W-1:0] pos_row, pos_col, near_row, near_col;
  logic [DIM_W-1:0]   row_acc, col_acc;
  logic [DIM_W-1:0]   row_whole, row_rem, col_whole, col_rem;

  pixel_addr_t expected_pixels[$];
  plan_row_t   directed_plan[$];
  int          errors = 0;
  bit          no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned live_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic int unsigned live_chan(input logic [CHAN_W-1:0] v);
    if (v == 0) return 1;
    if (v > CHAN_LIMIT) return CHAN_LIMIT;
    return v;
  endfunction

  function automatic int unsigned live_stride(input logic [STRIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > STRIDE_MAX) return STRIDE_MAX;
    return v;
  endfunction

  // quotient/remainder step of a nearest source index
  function automatic void step_source(inout logic [COORD_W-1:0] idx,
                                      inout logic [DIM_W-1:0] acc,
                                      input logic [DIM_W-1:0] whole,
                                      input logic [DIM_W-1:0] rem,
                                      input int unsigned out_size,
                                      input int unsigned in_size);
    int unsigned i, a;
    i = idx;
    i = i + whole;
    a = acc;
    a = a + rem;
    if (a >= out_size) begin
      a = a - out_size;
      i = i + 1;
    end
    if (i > in_size - 1) i = in_size - 1;
    idx = i[COORD_W-1:0];
    acc = a[DIM_W-1:0];
  endfunction

  function automatic pixel_addr_t next_pixel(input logic restart);
    int unsigned sw, sh, dw, dh, ch, ss, ds, sr, sc, orow, ocol;
    logic last_col, last_row;
    longint unsigned soff, doff;
    pixel_addr_t p;
    sw = live_dim(reg_src_w);
    sh = live_dim(reg_src_h);
    dw = live_dim(reg_dst_w);
    dh = live_dim(reg_dst_h);
    ch = live_chan(reg_chan);
    ss = live_stride(reg_src_stride);
    ds = live_stride(reg_dst_stride);
    if (restart || (pos_row == 0 && pos_col == 0)) begin
      pos_row = '0;
      pos_col = '0;
      near_row = '0;
      near_col = '0;
      row_acc = '0;
      col_acc = '0;
      row_whole = DIM_W'(sh / dh);
      row_rem = DIM_W'(sh % dh);
      col_whole = DIM_W'(sw / dw);
      col_rem = DIM_W'(sw % dw);
    end
    sr = near_row;
    if (sr > sh - 1) sr = sh - 1;
    sc = near_col;
    if (sc > sw - 1) sc = sw - 1;
    orow = pos_row;
    ocol = pos_col;
    last_col = (ocol + 1 >= dw);
    last_row = (orow + 1 >= dh);
    soff = longint'(sr) * ss + longint'(sc) * ch;
    doff = longint'(orow) * ds + longint'(ocol) * ch;
    p.dst_row = pos_row;
    p.dst_col = pos_col;
    p.src_row = sr[COORD_W-1:0];
    p.src_col = sc[COORD_W-1:0];
    p.src_offset = soff[OFS_W-1:0];
    p.dst_offset = doff[OFS_W-1:0];
    p.row_end = last_col;
    p.frame_end = last_col && last_row;
    if (last_col) begin
      pos_col = '0;
      near_col = '0;
      col_acc = '0;
      if (last_row) begin
        pos_row = '0;
        near_row = '0;
        row_acc = '0;
      end else begin
        pos_row = pos_row + 1'b1;
        step_source(near_row, row_acc, row_whole, row_rem, dh, sh);
      end
    end else begin
      pos_col = pos_col + 1'b1;
      step_source(near_col, col_acc, col_whole, col_rem, dw, sw);
    end
    return p;
  endfunction

  function automatic pixel_addr_t pix(input int unsigned drow, input int unsigned dcol,
                                      input int unsigned srow, input int unsigned scol,
                                      input int unsigned soff, input int unsigned doff,
                                      input logic rend, input logic fend);
    pixel_addr_t p;
    p.dst_row = drow[COORD_W-1:0];
    p.dst_col = dcol[COORD_W-1:0];
    p.src_row = srow[COORD_W-1:0];
    p.src_col = scol[COORD_W-1:0];
    p.src_offset = soff[OFS_W-1:0];
    p.dst_offset = doff[OFS_W-1:0];
    p.row_end = rend;
    p.frame_end = fend;
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] idx);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 95) return CFG_DATA_W'($urandom);
    case (idx)
      nrag_pkg::REG_CHANNEL_COUNT: return CFG_DATA_W'($urandom_range(0, 7));
      nrag_pkg::REG_SRC_ROW_STRIDE, nrag_pkg::REG_DST_ROW_STRIDE: begin
        if (r < 50) return CFG_DATA_W'($urandom_range(1, 64));
        return CFG_DATA_W'($urandom_range(0, 32767));
      end
      default: begin
        if (r < 70) return CFG_DATA_W'($urandom_range(1, 9));
        if (r < 82) return CFG_DATA_W'($urandom_range(10, 64));
        if (r < 86) return CFG_DATA_W'(DIM_LIMIT);
        if (r < 90) return '0;
        return CFG_DATA_W'($urandom_range(DIM_LIMIT + 1, 8191));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.index = idx;
    row.data = value;
    directed_plan.push_back(row);
  endtask

  task automatic plan_req(input logic restart, input logic has_lit, input pixel_addr_t lit);
    plan_row_t row;
    row = '0;
    row.restart = restart;
    row.has_lit = has_lit;
    row.lit = lit;
    directed_plan.push_back(row);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      nrag_pkg::REG_SRC_WIDTH:      reg_src_w = value[DIM_W-1:0];
      nrag_pkg::REG_SRC_HEIGHT:     reg_src_h = value[DIM_W-1:0];
      nrag_pkg::REG_DST_WIDTH:      reg_dst_w = value[DIM_W-1:0];
      nrag_pkg::REG_DST_HEIGHT:     reg_dst_h = value[DIM_W-1:0];
      nrag_pkg::REG_CHANNEL_COUNT:  reg_chan = value[CHAN_W-1:0];
      nrag_pkg::REG_SRC_ROW_STRIDE: reg_src_stride = value[STRIDE_W-1:0];
      nrag_pkg::REG_DST_ROW_STRIDE: reg_dst_stride = value[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // leaves in_valid high at the accepting edge so back-to-back requests need no toggle
  task automatic send_request(input logic restart, input logic use_lit, input pixel_addr_t lit);
    int gap;
    pixel_addr_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      restart_frame <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart_frame <= restart;
    do @(posedge clk); while (!in_ready);
    want = next_pixel(restart);
    expected_pixels.push_back(use_lit ? lit : want);
  endtask

  initial begin : result_side
    int stall;
    pixel_addr_t got, want;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.dst_row = dst_row;
        got.dst_col = dst_col;
        got.src_row = src_row;
        got.src_col = src_col;
        got.src_offset = src_offset;
        got.dst_offset = dst_offset;
        got.row_end = row_end;
        got.frame_end = frame_end;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result dst (%0d,%0d)", dst_row, dst_col));
        end else begin
          want = expected_pixels.pop_front();
          check_field("dst_row", 32'(got.dst_row), 32'(want.dst_row));
          check_field("dst_col", 32'(got.dst_col), 32'(want.dst_col));
          check_field("src_row", 32'(got.src_row), 32'(want.src_row));
          check_field("src_col", 32'(got.src_col), 32'(want.src_col));
          check_field("src_offset", 32'(got.src_offset), 32'(want.src_offset));
          check_field("dst_offset", 32'(got.dst_offset), 32'(want.dst_offset));
          check_field("row_end", 32'(got.row_end), 32'(want.row_end));
          check_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
        end
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    bit writing;
    int issued;
    int n;
    rst <= 1'b1;
    in_valid <= 1'b0;
    restart_frame <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    reg_src_w = 1;
    reg_src_h = 1;
    reg_dst_w = 1;
    reg_dst_h = 1;
    reg_chan = 1;
    reg_src_stride = 1;
    reg_dst_stride = 1;
    pos_row = '0;
    pos_col = '0;
    near_row = '0;
    near_col = '0;
    row_acc = '0;
    col_acc = '0;
    row_whole = '0;
    row_rem = '0;
    col_whole = '0;
    col_rem = '0;

    // reset sizes: every request is a one-pixel frame
    plan_req(1'b0, 1'b1, pix(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    plan_req(1'b1, 1'b1, pix(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    // largest source, 2x2 output, widest strides and channels
    plan_cfg(nrag_pkg::REG_SRC_WIDTH, 15'd4096);
    plan_cfg(nrag_pkg::REG_SRC_HEIGHT, 15'd4096);
    plan_cfg(nrag_pkg::REG_DST_WIDTH, 15'd2);
    plan_cfg(nrag_pkg::REG_DST_HEIGHT, 15'd2);
    plan_cfg(nrag_pkg::REG_CHANNEL_COUNT, 15'd4);
    plan_cfg(nrag_pkg::REG_SRC_ROW_STRIDE, 15'd16384);
    plan_cfg(nrag_pkg::REG_DST_ROW_STRIDE, 15'd16384);
    plan_req(1'b0, 1'b1, pix(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    plan_req(1'b0, 1'b1, pix(0, 1, 0, 2048, 8192, 4, 1'b1, 1'b0));
    plan_req(1'b0, 1'b1, pix(1, 0, 2048, 0, 33554432, 16384, 1'b0, 1'b0));
    plan_req(1'b0, 1'b1, pix(1, 1, 2048, 2048, 33562624, 16388, 1'b1, 1'b1));
    // zero and oversize register values
    plan_cfg(nrag_pkg::REG_SRC_WIDTH, 15'd0);
    plan_cfg(nrag_pkg::REG_SRC_HEIGHT, 15'd3);
    plan_cfg(nrag_pkg::REG_DST_WIDTH, 15'd0);
    plan_cfg(nrag_pkg::REG_DST_HEIGHT, 15'd8191);
    plan_cfg(nrag_pkg::REG_CHANNEL_COUNT, 15'd0);
    plan_cfg(nrag_pkg::REG_SRC_ROW_STRIDE, 15'd0);
    plan_cfg(nrag_pkg::REG_DST_ROW_STRIDE, 15'd32767);
    repeat (4) plan_req(1'b0, 1'b0, '0);
    plan_cfg(nrag_pkg::REG_CHANNEL_COUNT, 15'd7);
    plan_cfg(nrag_pkg::REG_SRC_WIDTH, 15'd8191);
    plan_cfg(nrag_pkg::REG_DST_WIDTH, 15'd8191);
    plan_cfg(nrag_pkg::REG_DST_HEIGHT, 15'd1);
    plan_cfg(nrag_pkg::REG_SRC_ROW_STRIDE, 15'd32767);
    plan_cfg(nrag_pkg::REG_DST_ROW_STRIDE, 15'd0);
    plan_cfg(UNUSED_REG, 15'h7fff);
    plan_req(1'b1, 1'b0, '0);
    repeat (3) plan_req(1'b0, 1'b0, '0);
    // sizes shrunk mid-frame: row ends early, source column saturates
    plan_cfg(nrag_pkg::REG_DST_WIDTH, 15'd2);
    plan_cfg(nrag_pkg::REG_SRC_WIDTH, 15'd2);
    repeat (2) plan_req(1'b0, 1'b0, '0);
    // fraction overshoots a shrunk output width
    plan_cfg(nrag_pkg::REG_SRC_WIDTH, 15'd7);
    plan_cfg(nrag_pkg::REG_DST_WIDTH, 15'd5);
    plan_cfg(nrag_pkg::REG_CHANNEL_COUNT, 15'd3);
    plan_req(1'b1, 1'b0, '0);
    plan_req(1'b0, 1'b0, '0);
    plan_cfg(nrag_pkg::REG_DST_WIDTH, 15'd4);
    repeat (3) plan_req(1'b0, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    writing = 1'b0;
    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_cfg) begin
        if (!writing) wait_drained();
        writing = 1'b1;
        write_reg(directed_plan[k].index, directed_plan[k].data);
      end else begin
        if (writing) cfg_write <= 1'b0;
        writing = 1'b0;
        send_request(directed_plan[k].restart, directed_plan[k].has_lit,
                     directed_plan[k].lit);
      end
    end

    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      wait_drained();
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'(r), pick_value(CFG_IDX_W'(r)));
      end
      cfg_write <= 1'b0;
      no_idle = ($urandom_range(0, 4) == 0);
      n = $urandom_range(10, 60);
      for (int j = 0; j < n; j++) begin
        send_request((j == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 31) == 0),
                     1'b0, '0);
      end
      issued += n;
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
